// ----- rtl/great_circle_distance_bearing_core_defines.svh -----
// ----------------------------------------------------------------------------
// Great-circle core assertion macros
// Concurrent checks on clk with rst_n low disabling them; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef GREAT_CIRCLE_DISTANCE_BEARING_CORE_DEFINES_SVH
`define GREAT_CIRCLE_DISTANCE_BEARING_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define GCDB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gcdb: same-cycle check failed");
`define GCDB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gcdb: next-cycle check failed");
`else
`define GCDB_ASSERT_IMP(lbl, ante, cons)
`define GCDB_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/gcdb_pkg.sv -----
// ----------------------------------------------------------------------------
// Great-circle core package
// Shared constants, CORDIC arctangent table, stage counts and Q30 multiply.
// ----------------------------------------------------------------------------
package gcdb_pkg;

  localparam int ANGLE_FRAC_BITS_DEF = 23;

  localparam logic [22:0] RADIUS_RESET = 23'd6371000;
  localparam logic [24:0] DIST_MAX     = 25'd20420352;
  localparam logic [31:0] TWO_PI_Q29   = 32'd3373259426;

  // floor(2^37 / 45), used for divide-by-45 with one correction step
  localparam logic [31:0] RECIP_45       = 32'd3054198966;
  localparam int          RECIP_45_SHIFT = 37;

  localparam logic signed [33:0] Q30_ONE         = 34'sd1073741824;
  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

  localparam int CORDIC_STEPS           = 24;
  localparam int CORDIC_STEPS_PER_STAGE = 3;
  localparam int CORDIC_STAGES          = CORDIC_STEPS / CORDIC_STEPS_PER_STAGE;

  localparam int SQRT_BITS            = 31;
  localparam int SQRT_STEPS_PER_STAGE = 2;
  localparam int SQRT_STAGES          =
    (SQRT_BITS + SQRT_STEPS_PER_STAGE - 1) / SQRT_STEPS_PER_STAGE;

  localparam int CONV_STAGES = 4;

  localparam logic signed [33:0] ATAN_BAM [CORDIC_STEPS] = '{
    34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
    34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
    34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
    34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
    34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
    34'sd652,       34'sd326,       34'sd163,       34'sd81
  };

  typedef logic signed [31:0] q30_t;

  // Q30 product, rounded half up
  function automatic q30_t qmul(input q30_t a, input q30_t b);
    logic signed [63:0] p;
    p = a * b + 64'sd536870912;
    return p[61:30];
  endfunction

endpackage

// ----- rtl/great_circle_distance_bearing_core.sv -----
// ----------------------------------------------------------------------------
// Great-circle distance and initial bearing core
// Haversine distance in meters and initial bearing between two points.
// ----------------------------------------------------------------------------
// Usage:
//   Input request: start with in_start_lat/lon and in_end_lat/lon, degrees
//   times 2^ANGLE_FRACTION_BITS. A request is taken when start is high and
//   busy is low; busy stays low, so one request can enter every cycle.
//   Result: out_strobe is high for one cycle with out_distance_m and
//   out_bearing_deg. The receiver cannot stall; results simply flow out.
//   Every request passes 4 conversion, 1 difference, 8 sine/cosine CORDIC,
//   3 multiply, 16 square root, 8 atan2 CORDIC and 3 scaling stages.
//   Throughput is one request per cycle, set by the fully pipelined CORDIC
//   and square-root units.
//   cfg_we with cfg_wdata sets the sphere radius in meters; write it only
//   while no request is in flight.
//   Reset (rst_n low, synchronous) clears all stage valid bits, drops any
//   request in flight and sets the radius to 6371000 m.
// ----------------------------------------------------------------------------
`include "great_circle_distance_bearing_core_defines.svh"

module great_circle_distance_bearing_core import gcdb_pkg::*; #(
  parameter int ANGLE_FRACTION_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [30:0] in_start_lat,
  input  logic signed [31:0] in_start_lon,
  input  logic signed [30:0] in_end_lat,
  input  logic signed [31:0] in_end_lon,
  output logic               out_strobe,
  output logic [24:0]        out_distance_m,
  output logic [31:0]        out_bearing_deg,
  input  logic               cfg_we,
  input  logic [22:0]        cfg_wdata
);

  localparam int BSH = 32 - ANGLE_FRACTION_BITS;
  localparam logic [32:0] DEG_WRAP = 33'd360 << ANGLE_FRACTION_BITS;
  localparam logic [30:0] Q30_ONE_U = 31'h4000_0000;
  localparam int COIN_DLY = CORDIC_STAGES + 3 + SQRT_STAGES + CORDIC_STAGES;
  localparam int ZERO_DLY = SQRT_STAGES + CORDIC_STAGES;
  localparam int BAM_DLY  = SQRT_STAGES;

  logic        acc;
  logic [22:0] radius_r;

  // conversion
  logic        cv_vld;
  logic [31:0] bam_lat1, bam_lon1, bam_lat2, bam_lon2;

  // differences
  logic        p1_vld_r;
  logic [31:0] lat1_r, lat2_r, dlat_r, dlon_r;
  logic        coin_r;

  // sine / cosine
  logic rt_vld;
  q30_t s1, c1, s2, c2, sh, sl, sd, cd;

  // products
  logic m1_vld_r;
  q30_t p_sh_r, p_cc_r, p_ll_r, by_r, p_cs_r, p_sc_r, cd_r;
  logic m2_vld_r;
  q30_t p_sh2_r, t_r, p_cs2_r, t2_r, by2_r;
  logic               m3_vld_r;
  logic signed [32:0] a_sum;
  logic [30:0]        a_nxt;
  logic [30:0]        a_r;
  logic signed [32:0] bx_r, by3_r;
  logic               bzero;

  // roots and angles
  logic               sq_vld;
  logic [30:0]        sa, sb;
  logic               hv_vld;
  logic signed [33:0] half;
  logic signed [33:0] bz;

  logic        coin_dly_r [COIN_DLY];
  logic        zero_dly_r [ZERO_DLY];
  logic [31:0] bam_dly_r  [BAM_DLY];

  // scaling
  logic [30:0] half_c;
  logic [31:0] theta;
  logic        f1_vld_r, f1_coin_r, f1_zero_r;
  logic [54:0] prodr_r;
  logic [40:0] prodb_r;
  logic        f2_vld_r, f2_coin_r;
  logic [63:0] prodd_r;
  logic [41:0] deg_sum;
  logic [41:0] deg_full;
  logic [31:0] deg_nxt;
  logic [31:0] deg_r;
  logic [64:0] dist_sum;
  logic [25:0] dist_full;
  logic [24:0] dist_nxt;
  logic        out_strobe_r;
  logic [24:0] out_distance_m_r;
  logic [31:0] out_bearing_deg_r;

  assign busy = 1'b0;
  assign acc  = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RESET;
    end else if (cfg_we) begin
      radius_r <= cfg_wdata;
    end
  end

  gcdb_bam_conv #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)) u_conv_lat1 (
    .clk(clk), .rst_n(rst_n), .in_vld(acc),
    .in_ang({in_start_lat[30], in_start_lat}),
    .out_vld(cv_vld), .out_bam(bam_lat1)
  );
  gcdb_bam_conv #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)) u_conv_lon1 (
    .clk(clk), .rst_n(rst_n), .in_vld(acc), .in_ang(in_start_lon),
    .out_vld(), .out_bam(bam_lon1)
  );
  gcdb_bam_conv #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)) u_conv_lat2 (
    .clk(clk), .rst_n(rst_n), .in_vld(acc),
    .in_ang({in_end_lat[30], in_end_lat}),
    .out_vld(), .out_bam(bam_lat2)
  );
  gcdb_bam_conv #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)) u_conv_lon2 (
    .clk(clk), .rst_n(rst_n), .in_vld(acc), .in_ang(in_end_lon),
    .out_vld(), .out_bam(bam_lon2)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else begin
      p1_vld_r <= cv_vld;
    end
  end

  always_ff @(posedge clk) begin
    lat1_r <= bam_lat1;
    lat2_r <= bam_lat2;
    dlat_r <= bam_lat2 - bam_lat1;
    dlon_r <= bam_lon2 - bam_lon1;
    coin_r <= (bam_lat1 == bam_lat2) && (bam_lon1 == bam_lon2);
  end

  gcdb_cordic_rot u_rot_lat1 (
    .clk(clk), .rst_n(rst_n), .in_vld(p1_vld_r), .in_bam(lat1_r),
    .out_vld(rt_vld), .out_sin(s1), .out_cos(c1)
  );
  gcdb_cordic_rot u_rot_lat2 (
    .clk(clk), .rst_n(rst_n), .in_vld(p1_vld_r), .in_bam(lat2_r),
    .out_vld(), .out_sin(s2), .out_cos(c2)
  );
  gcdb_cordic_rot u_rot_hdlat (
    .clk(clk), .rst_n(rst_n), .in_vld(p1_vld_r), .in_bam({1'b0, dlat_r[31:1]}),
    .out_vld(), .out_sin(sh), .out_cos()
  );
  gcdb_cordic_rot u_rot_hdlon (
    .clk(clk), .rst_n(rst_n), .in_vld(p1_vld_r), .in_bam({1'b0, dlon_r[31:1]}),
    .out_vld(), .out_sin(sl), .out_cos()
  );
  gcdb_cordic_rot u_rot_dlon (
    .clk(clk), .rst_n(rst_n), .in_vld(p1_vld_r), .in_bam(dlon_r),
    .out_vld(), .out_sin(sd), .out_cos(cd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r <= 1'b0;
      m2_vld_r <= 1'b0;
      m3_vld_r <= 1'b0;
    end else begin
      m1_vld_r <= rt_vld;
      m2_vld_r <= m1_vld_r;
      m3_vld_r <= m2_vld_r;
    end
  end

  // haversine term and bearing vector
  always_comb begin
    a_sum = 33'(p_sh2_r) + 33'(t_r);
    if (a_sum < 0) begin
      a_nxt = '0;
    end else if (a_sum > 33'sd1073741824) begin
      a_nxt = Q30_ONE_U;
    end else begin
      a_nxt = a_sum[30:0];
    end
  end

  always_ff @(posedge clk) begin
    p_sh_r  <= qmul(sh, sh);
    p_cc_r  <= qmul(c1, c2);
    p_ll_r  <= qmul(sl, sl);
    by_r    <= qmul(sd, c2);
    p_cs_r  <= qmul(c1, s2);
    p_sc_r  <= qmul(s1, c2);
    cd_r    <= cd;
    p_sh2_r <= p_sh_r;
    t_r     <= qmul(p_cc_r, p_ll_r);
    p_cs2_r <= p_cs_r;
    t2_r    <= qmul(p_sc_r, cd_r);
    by2_r   <= by_r;
    a_r     <= a_nxt;
    bx_r    <= 33'(p_cs2_r) - 33'(t2_r);
    by3_r   <= 33'(by2_r);
  end

  assign bzero = (bx_r == '0) && (by3_r == '0);

  gcdb_isqrt u_sqrt_a (
    .clk(clk), .rst_n(rst_n), .in_vld(m3_vld_r), .in_a(a_r),
    .out_vld(sq_vld), .out_root(sa)
  );
  gcdb_isqrt u_sqrt_b (
    .clk(clk), .rst_n(rst_n), .in_vld(m3_vld_r), .in_a(Q30_ONE_U - a_r),
    .out_vld(), .out_root(sb)
  );

  gcdb_cordic_vec u_vec_dist (
    .clk(clk), .rst_n(rst_n), .in_vld(sq_vld),
    .in_y({2'b00, sa}), .in_x({2'b00, sb}),
    .out_vld(hv_vld), .out_z(half)
  );
  gcdb_cordic_vec u_vec_bear (
    .clk(clk), .rst_n(rst_n), .in_vld(m3_vld_r),
    .in_y(by3_r), .in_x(bx_r),
    .out_vld(), .out_z(bz)
  );

  // side flags and bearing angle line up with the distance path
  always_ff @(posedge clk) begin
    coin_dly_r[0] <= coin_r;
    for (int k = 1; k < COIN_DLY; k++) begin
      coin_dly_r[k] <= coin_dly_r[k-1];
    end
    zero_dly_r[0] <= bzero;
    for (int k = 1; k < ZERO_DLY; k++) begin
      zero_dly_r[k] <= zero_dly_r[k-1];
    end
    bam_dly_r[0] <= bz[31:0];
    for (int k = 1; k < BAM_DLY; k++) begin
      bam_dly_r[k] <= bam_dly_r[k-1];
    end
  end

  always_comb begin
    if (half < 0) begin
      half_c = '0;
    end else if (half > Q30_ONE) begin
      half_c = Q30_ONE_U;
    end else begin
      half_c = half[30:0];
    end
    theta = {half_c, 1'b0};
  end

  always_comb begin
    deg_sum  = 42'(prodb_r) + (42'd1 << (BSH - 1));
    deg_full = deg_sum >> BSH;
    if (f1_coin_r || f1_zero_r || (deg_full[32:0] >= DEG_WRAP)) begin
      deg_nxt = '0;
    end else begin
      deg_nxt = deg_full[31:0];
    end
  end

  always_comb begin
    dist_sum  = 65'(prodd_r) + (65'd1 << 38);
    dist_full = dist_sum[64:39];
    if (f2_coin_r) begin
      dist_nxt = '0;
    end else if (dist_full > 26'(DIST_MAX)) begin
      dist_nxt = DIST_MAX;
    end else begin
      dist_nxt = dist_full[24:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r     <= 1'b0;
      f2_vld_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      f1_vld_r     <= hv_vld;
      f2_vld_r     <= f1_vld_r;
      out_strobe_r <= f2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    prodr_r           <= 55'(radius_r) * 55'(theta);
    prodb_r           <= 41'(bam_dly_r[BAM_DLY-1]) * 41'd360;
    f1_coin_r         <= coin_dly_r[COIN_DLY-1];
    f1_zero_r         <= zero_dly_r[ZERO_DLY-1];
    prodd_r           <= 64'(prodr_r[53:22]) * 64'(TWO_PI_Q29);
    deg_r             <= deg_nxt;
    f2_coin_r         <= f1_coin_r;
    out_distance_m_r  <= dist_nxt;
    out_bearing_deg_r <= deg_r;
  end

  assign out_strobe      = out_strobe_r;
  assign out_distance_m  = out_distance_m_r;
  assign out_bearing_deg = out_bearing_deg_r;

  `GCDB_ASSERT_IMP(a_dist_range, out_strobe_r, out_distance_m_r <= DIST_MAX)
  `GCDB_ASSERT_IMP(a_bear_range, out_strobe_r, 33'(out_bearing_deg_r) < DEG_WRAP)
  `GCDB_ASSERT_NXT(a_coin_zero, f2_vld_r && f2_coin_r, out_strobe_r && (out_distance_m_r == '0) && (out_bearing_deg_r == '0))

endmodule

// ----- rtl/gcdb_bam_conv.sv -----
// ----------------------------------------------------------------------------
// Degree to binary-angle converter
// round(v * 2^(32-F) / 360), ties away from zero, as two divide-by-45 passes.
// ----------------------------------------------------------------------------
module gcdb_bam_conv import gcdb_pkg::*; #(
  parameter int ANGLE_FRACTION_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic signed [31:0] in_ang,
  output logic               out_vld,
  output logic [31:0]        out_bam
);

  localparam int SH = 29 - ANGLE_FRACTION_BITS;

  logic [CONV_STAGES-1:0] vld_r;

  logic [31:0] ang_u;
  logic [31:0] mag_nxt;
  logic        neg1_r;
  logic [31:0] mag1_r;
  logic [63:0] prod1_r;

  logic [26:0] a0;
  logic [31:0] r0;
  logic [26:0] a_nxt;
  logic [5:0]  b_nxt;
  logic [19:0] w_nxt;
  logic        neg2_r;
  logic [26:0] a2_r;
  logic [19:0] w2_r;

  logic        neg3_r;
  logic [26:0] a3_r;
  logic [19:0] w3_r;
  logic [63:0] prod2_r;

  logic [14:0] c0;
  logic [19:0] r2;
  logic [14:0] c;
  logic [31:0] q;
  logic [31:0] bam_nxt;
  logic [31:0] bam_r;

  always_comb begin
    ang_u   = in_ang;
    mag_nxt = ang_u[31] ? (~ang_u + 32'd1) : ang_u;
  end

  // |v| = 45a + b
  always_comb begin
    a0 = prod1_r[RECIP_45_SHIFT+26:RECIP_45_SHIFT];
    r0 = mag1_r - 32'(a0) * 32'd45;
    if (r0 >= 32'd45) begin
      a_nxt = a0 + 27'd1;
      b_nxt = 6'(r0 - 32'd45);
    end else begin
      a_nxt = a0;
      b_nxt = 6'(r0);
    end
    w_nxt = (20'(b_nxt) << SH) + 20'd22;
  end

  always_comb begin
    c0 = prod2_r[RECIP_45_SHIFT+14:RECIP_45_SHIFT];
    r2 = w3_r - 20'(c0) * 20'd45;
    c  = (r2 >= 20'd45) ? c0 + 15'd1 : c0;
    q  = (32'(a3_r) << SH) + 32'(c);
    bam_nxt = neg3_r ? (~q + 32'd1) : q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[CONV_STAGES-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    neg1_r  <= ang_u[31];
    mag1_r  <= mag_nxt;
    prod1_r <= 64'(mag_nxt) * 64'(RECIP_45);
    neg2_r  <= neg1_r;
    a2_r    <= a_nxt;
    w2_r    <= w_nxt;
    neg3_r  <= neg2_r;
    a3_r    <= a2_r;
    w3_r    <= w2_r;
    prod2_r <= 64'(w2_r) * 64'(RECIP_45);
    bam_r   <= bam_nxt;
  end

  assign out_vld = vld_r[CONV_STAGES-1];
  assign out_bam = bam_r;

endmodule

// ----- rtl/gcdb_cordic_rot.sv -----
// ----------------------------------------------------------------------------
// Rotation CORDIC
// Sine and cosine of a binary angle in Q30, pipelined a few steps per stage.
// ----------------------------------------------------------------------------
module gcdb_cordic_rot import gcdb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  logic [31:0] in_bam,
  output logic        out_vld,
  output q30_t        out_sin,
  output q30_t        out_cos
);

  localparam int LAST = CORDIC_STAGES - 1;

  logic signed [33:0] z_fold;
  logic               neg_fold;

  logic                      vld_r [CORDIC_STAGES];
  logic signed [33:0]        x_r   [CORDIC_STAGES];
  logic signed [33:0]        y_r   [CORDIC_STAGES];
  logic signed [33:0]        z_r   [CORDIC_STAGES];
  logic                      neg_r [CORDIC_STAGES];

  logic signed [33:0] sin_f;
  logic signed [33:0] cos_f;

  // fold into [-90, 90] degrees, negate results afterwards
  always_comb begin
    z_fold   = 34'(signed'(in_bam));
    neg_fold = 1'b0;
    if (z_fold > Q30_ONE) begin
      z_fold   = z_fold - 34'sd2147483648;
      neg_fold = 1'b1;
    end else if (z_fold < -Q30_ONE) begin
      z_fold   = z_fold + 34'sd2147483648;
      neg_fold = 1'b1;
    end
  end

  for (genvar st = 0; st < CORDIC_STAGES; st++) begin : g_stage
    logic signed [33:0] xs, ys, zs;
    logic signed [33:0] xn, yn, zn;
    logic               ns, vs;

    if (st == 0) begin : g_first
      assign xs = CORDIC_GAIN_Q30;
      assign ys = '0;
      assign zs = z_fold;
      assign ns = neg_fold;
      assign vs = in_vld;
    end else begin : g_next
      assign xs = x_r[st-1];
      assign ys = y_r[st-1];
      assign zs = z_r[st-1];
      assign ns = neg_r[st-1];
      assign vs = vld_r[st-1];
    end

    always_comb begin
      xn = xs;
      yn = ys;
      zn = zs;
      for (int j = 0; j < CORDIC_STEPS_PER_STAGE; j++) begin
        logic signed [33:0] tx, ty;
        tx = xn;
        ty = yn;
        if (zn >= 0) begin
          xn = tx - (ty >>> (st * CORDIC_STEPS_PER_STAGE + j));
          yn = ty + (tx >>> (st * CORDIC_STEPS_PER_STAGE + j));
          zn = zn - ATAN_BAM[st * CORDIC_STEPS_PER_STAGE + j];
        end else begin
          xn = tx + (ty >>> (st * CORDIC_STEPS_PER_STAGE + j));
          yn = ty - (tx >>> (st * CORDIC_STEPS_PER_STAGE + j));
          zn = zn + ATAN_BAM[st * CORDIC_STEPS_PER_STAGE + j];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[st] <= 1'b0;
      end else begin
        vld_r[st] <= vs;
      end
    end

    always_ff @(posedge clk) begin
      x_r[st]   <= xn;
      y_r[st]   <= yn;
      z_r[st]   <= zn;
      neg_r[st] <= ns;
    end
  end

  always_comb begin
    sin_f = neg_r[LAST] ? -y_r[LAST] : y_r[LAST];
    cos_f = neg_r[LAST] ? -x_r[LAST] : x_r[LAST];
  end

  assign out_vld = vld_r[LAST];
  assign out_sin = sin_f[31:0];
  assign out_cos = cos_f[31:0];

endmodule

// ----- rtl/gcdb_cordic_vec.sv -----
// ----------------------------------------------------------------------------
// Vectoring CORDIC
// atan2(y, x) in binary angle units, unwrapped, pipelined a few steps per stage.
// ----------------------------------------------------------------------------
module gcdb_cordic_vec import gcdb_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic signed [32:0] in_y,
  input  logic signed [32:0] in_x,
  output logic               out_vld,
  output logic signed [33:0] out_z
);

  localparam int LAST = CORDIC_STAGES - 1;

  logic signed [35:0] x_pre, y_pre;
  logic signed [33:0] z_pre;

  logic               vld_r [CORDIC_STAGES];
  logic signed [35:0] x_r   [CORDIC_STAGES];
  logic signed [35:0] y_r   [CORDIC_STAGES];
  logic signed [33:0] z_r   [CORDIC_STAGES];

  // left half plane: turn by 180 degrees first
  always_comb begin
    x_pre = 36'(in_x);
    y_pre = 36'(in_y);
    z_pre = '0;
    if (in_x < 0) begin
      x_pre = -36'(in_x);
      y_pre = -36'(in_y);
      z_pre = 34'sd2147483648;
    end
  end

  for (genvar st = 0; st < CORDIC_STAGES; st++) begin : g_stage
    logic signed [35:0] xs, ys, xn, yn;
    logic signed [33:0] zs, zn;
    logic               vs;

    if (st == 0) begin : g_first
      assign xs = x_pre;
      assign ys = y_pre;
      assign zs = z_pre;
      assign vs = in_vld;
    end else begin : g_next
      assign xs = x_r[st-1];
      assign ys = y_r[st-1];
      assign zs = z_r[st-1];
      assign vs = vld_r[st-1];
    end

    always_comb begin
      xn = xs;
      yn = ys;
      zn = zs;
      for (int j = 0; j < CORDIC_STEPS_PER_STAGE; j++) begin
        logic signed [35:0] tx, ty;
        tx = xn;
        ty = yn;
        if (ty >= 0) begin
          xn = tx + (ty >>> (st * CORDIC_STEPS_PER_STAGE + j));
          yn = ty - (tx >>> (st * CORDIC_STEPS_PER_STAGE + j));
          zn = zn + ATAN_BAM[st * CORDIC_STEPS_PER_STAGE + j];
        end else begin
          xn = tx - (ty >>> (st * CORDIC_STEPS_PER_STAGE + j));
          yn = ty + (tx >>> (st * CORDIC_STEPS_PER_STAGE + j));
          zn = zn - ATAN_BAM[st * CORDIC_STEPS_PER_STAGE + j];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[st] <= 1'b0;
      end else begin
        vld_r[st] <= vs;
      end
    end

    always_ff @(posedge clk) begin
      x_r[st] <= xn;
      y_r[st] <= yn;
      z_r[st] <= zn;
    end
  end

  assign out_vld = vld_r[LAST];
  assign out_z   = z_r[LAST];

endmodule

// ----- rtl/gcdb_isqrt.sv -----
// ----------------------------------------------------------------------------
// Integer square root
// floor(sqrt(a * 2^30)) for a Q30 value, digit by digit, pipelined.
// ----------------------------------------------------------------------------
module gcdb_isqrt import gcdb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  logic [SQRT_BITS-1:0] in_a,
  output logic                 out_vld,
  output logic [SQRT_BITS-1:0] out_root
);

  localparam int LAST = SQRT_STAGES - 1;
  localparam int RW   = 2 * SQRT_BITS + 1;

  logic                 vld_r  [SQRT_STAGES];
  logic [RW-1:0]        rem_r  [SQRT_STAGES];
  logic [SQRT_BITS-1:0] root_r [SQRT_STAGES];

  for (genvar st = 0; st < SQRT_STAGES; st++) begin : g_stage
    logic [RW-1:0]        rs, rn;
    logic [SQRT_BITS-1:0] qs, qn;
    logic                 vs;

    if (st == 0) begin : g_first
      assign rs = RW'({in_a, 30'b0});
      assign qs = '0;
      assign vs = in_vld;
    end else begin : g_next
      assign rs = rem_r[st-1];
      assign qs = root_r[st-1];
      assign vs = vld_r[st-1];
    end

    // rem holds v - root^2; trial is (root + 2^b)^2 - root^2
    always_comb begin
      rn = rs;
      qn = qs;
      for (int j = 0; j < SQRT_STEPS_PER_STAGE; j++) begin
        logic [RW-1:0] trial;
        trial = '0;
        if (st * SQRT_STEPS_PER_STAGE + j < SQRT_BITS) begin
          trial = (RW'(qn) << (SQRT_BITS - st * SQRT_STEPS_PER_STAGE - j))
                + (RW'(1) << (2 * (SQRT_BITS - 1 - st * SQRT_STEPS_PER_STAGE - j)));
          if (rn >= trial) begin
            rn = rn - trial;
            qn = qn | (SQRT_BITS'(1) << (SQRT_BITS - 1 - st * SQRT_STEPS_PER_STAGE - j));
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[st] <= 1'b0;
      end else begin
        vld_r[st] <= vs;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[st]  <= rn;
      root_r[st] <= qn;
    end
  end

  assign out_vld  = vld_r[LAST];
  assign out_root = root_r[LAST];

endmodule
